/* rtl/five_register_keystream_cipher_defines.svh */
// Assertion macros shared by the checker of the keystream cipher.
`ifndef FIVE_REGISTER_KEYSTREAM_CIPHER_DEFINES_SVH
`define FIVE_REGISTER_KEYSTREAM_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define FKC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fkc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define FKC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fkc assertion failed");

`endif

/* rtl/fkc_pkg.sv */
// Types, constants and helper functions of the five-register keystream cipher.
package fkc_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned NUM_BYTES = WORD_W / 8;
    localparam int unsigned BCNT_W    = 4;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned ROT_S0  = 2;
    localparam int unsigned ROT_S1  = 7;
    localparam int unsigned ROT_S2  = 9;
    localparam int unsigned ROT_S3  = 12;
    localparam int unsigned ROT_ACC = 5;

    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [BCNT_W-1:0] t_bcnt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0 = 3'd0,
        CFG_KEY1 = 3'd1,
        CFG_KEY2 = 3'd2,
        CFG_KEY3 = 3'd3,
        CFG_IV0  = 3'd4,
        CFG_IV1  = 3'd5
    } t_cfg_index;

    typedef struct packed {
        t_word [3:0] key;
        t_word [1:0] iv;
    } t_cfg;

    typedef struct packed {
        logic  load;
        t_word ks;
    } t_ks_req;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SUM,
        ST_MIX,
        ST_FIN
    } t_setup_state;

    function automatic t_word rotl(input t_word a, input int unsigned n);
        return (a << n) | (a >> (WORD_W - n));
    endfunction

    function automatic t_word mix_word(input t_word r, input int unsigned l1,
                                       input int unsigned l2, input int unsigned r1,
                                       input int unsigned r2);
        return (r << l1) ^ (r << l2) ^ (r >> r1) ^ (r >> r2);
    endfunction

    function automatic t_bcnt clamp_count(input t_bcnt n);
        return (n > t_bcnt'(NUM_BYTES)) ? t_bcnt'(NUM_BYTES) : n;
    endfunction

    function automatic t_word byte_mask(input t_bcnt n);
        t_word m;
        for (int j = 0; j < NUM_BYTES; j++) begin
            m[8*j +: 8] = {8{t_bcnt'(j) < n}};
        end
        return m;
    endfunction

endpackage

/* rtl/fkc_cfg_regs.sv */
// Key and IV configuration registers of the keystream cipher.
module fkc_cfg_regs
    import fkc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  t_word                i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (t_cfg_index'(i_index))
                CFG_KEY0: n_cfg.key[0] = i_data;
                CFG_KEY1: n_cfg.key[1] = i_data;
                CFG_KEY2: n_cfg.key[2] = i_data;
                CFG_KEY3: n_cfg.key[3] = i_data;
                CFG_IV0:  n_cfg.iv[0]  = i_data;
                CFG_IV1:  n_cfg.iv[1]  = i_data;
                default:  n_cfg       = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/fkc_core.sv */
// Cipher state registers, data-block step and the key setup sequencer.
module fkc_core
    import fkc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_restart,
    input  logic  i_step,
    output logic  o_idle,
    output t_word o_ks
);

    t_setup_state r_state;
    t_setup_state n_state;
    t_word [3:0]  r_s;
    t_word [3:0]  n_s;
    t_word        r_acc;
    t_word        n_acc;
    t_word        r_t;
    t_word        n_t;
    t_word        r_sum;
    t_word        n_sum;
    logic [1:0]   r_idx;
    logic [1:0]   n_idx;

    t_word [3:0]  step_m;
    t_word [3:0]  step_s;
    t_word        step_acc;
    t_word        mix_t;

    // Data-block step: shift-XOR maps, accumulator add, then the rotations.
    always_comb begin
        step_m[0] = mix_word(r_s[0], 11, 12, 6, 3);
        step_m[1] = mix_word(r_s[1], 9, 13, 5, 1);
        step_m[2] = mix_word(r_s[2], 1, 2, 3, 1);
        step_m[3] = mix_word(r_s[3], 14, 16, 7, 2);
        step_acc  = rotl(r_acc + step_m[0] + step_m[1] + step_m[2] + step_m[3], ROT_ACC);
        step_s[0] = rotl(step_m[0], ROT_S0);
        step_s[1] = rotl(step_m[1], ROT_S1);
        step_s[2] = rotl(step_m[2], ROT_S2);
        step_s[3] = rotl(step_m[3], ROT_S3);
        o_ks      = step_s[0] ^ step_s[1] ^ step_s[2] ^ step_s[3] ^ step_acc;
        mix_t     = r_sum + r_t;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (i_restart) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: n_state = ST_MIX;
            ST_MIX: begin
                if (r_idx == 2'd3) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: n_state = ST_RUN;
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        o_idle = (r_state == ST_RUN);
    end

    always_comb begin
        n_s   = r_s;
        n_acc = r_acc;
        n_t   = r_t;
        n_sum = r_sum;
        n_idx = r_idx;
        unique case (r_state)
            ST_RUN: begin
                if (i_restart) begin
                    n_s[0] = i_cfg.key[0];
                    n_s[1] = i_cfg.key[1];
                    n_s[2] = i_cfg.key[2] ^ i_cfg.iv[0];
                    n_s[3] = i_cfg.key[3] ^ i_cfg.iv[1];
                    n_acc  = i_cfg.key[0] + i_cfg.key[1] + i_cfg.key[2] + i_cfg.key[3];
                    n_idx  = 2'd0;
                end else if (i_step) begin
                    n_s   = step_s;
                    n_acc = step_acc;
                end
            end
            ST_SUM: begin
                n_sum = r_s[0] + r_s[1] + r_s[2] + r_s[3];
                n_t   = r_s[0] + r_s[1] + r_s[2] + r_s[3] + t_word'(1);
            end
            ST_MIX: begin
                // The running sum tracks the register being replaced.
                n_s[r_idx] = mix_t;
                n_t        = mix_t;
                n_sum      = r_sum + r_sum + r_t - r_s[r_idx];
                n_idx      = r_idx + 2'd1;
            end
            ST_FIN: begin
                n_acc  = rotl(r_acc + r_s[1] + r_s[2] + r_s[3], ROT_ACC);
                n_s[0] = rotl(r_s[0], ROT_S0);
                n_s[1] = rotl(r_s[1], ROT_S1);
                n_s[2] = rotl(r_s[2], ROT_S2);
                n_s[3] = rotl(r_s[3], ROT_S3);
            end
            default: n_s = r_s;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_s     <= '0;
            r_acc   <= '0;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_s     <= n_s;
            r_acc   <= n_acc;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t   <= n_t;
        r_sum <= n_sum;
    end

endmodule

/* rtl/fkc_out.sv */
// Result register: applies the keystream, masks unused bytes and holds the result.
module fkc_out
    import fkc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ks_req i_req,
    input  t_word   i_data_in,
    input  t_bcnt   i_byte_count,
    input  logic    i_out_ready,
    output logic    o_slot_free,
    output logic    o_out_valid,
    output t_word   o_data_out,
    output t_bcnt   o_valid_bytes
);

    logic  r_valid;
    logic  n_valid;
    t_word r_data;
    t_bcnt r_bytes;
    t_bcnt n_bytes;
    t_word n_data;

    always_comb begin
        o_slot_free = !r_valid || i_out_ready;
        n_bytes     = clamp_count(i_byte_count);
        n_data      = (i_data_in ^ i_req.ks) & byte_mask(n_bytes);
        n_valid     = i_req.load || (r_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_data  <= n_data;
            r_bytes <= n_bytes;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_data_out    = r_data;
    assign o_valid_bytes = r_bytes;

endmodule

/* rtl/five_register_keystream_cipher.sv */
// Five-register keystream cipher: top level.
// Three channels, each with valid and ready. The configuration channel writes the
// key and IV words by index; it is always ready and a write takes effect at the
// next restart request. The input channel carries one request per cycle while it is ready:
// a restart request runs the key setup and gives no result, a data request encrypts up to
// eight message bytes and gives one result on the output channel.
// A data request updates the cipher state at the edge it is accepted; its result is
// registered at that edge and visible in the cycle after, and throughput is one
// data request per cycle while the receiver takes every result.
// A restart request occupies the key setup sequencer, which steps through ST_SUM,
// one ST_MIX per state register and ST_FIN, with input ready held low meanwhile.
// When the receiver stalls, the result register holds its value and input ready
// falls until the result is taken; a new request is accepted in the cycle the
// waiting result leaves.
// Reset clears the key, IV and cipher state to zero and empties the result
// register; no clearing pass is needed.
module five_register_keystream_cipher
    import fkc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_word                i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  t_word                i_data_in,
    input  t_bcnt                i_byte_count,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_word                o_data_out,
    output t_bcnt                o_valid_bytes
);

    t_cfg    cfg;
    t_ks_req ks_req;
    t_word   ks;
    logic    core_idle;
    logic    slot_free;
    logic    in_accept;
    logic    restart;
    logic    step;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = core_idle && slot_free;
    assign in_accept   = i_in_valid && o_in_ready;
    assign restart     = in_accept && (i_kind == KIND_RESTART);
    assign step        = in_accept && (i_kind == KIND_DATA);
    assign ks_req.load = step;
    assign ks_req.ks   = ks;

    fkc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    fkc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (restart),
        .i_step    (step),
        .o_idle    (core_idle),
        .o_ks      (ks)
    );

    fkc_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (ks_req),
        .i_data_in     (i_data_in),
        .i_byte_count  (i_byte_count),
        .i_out_ready   (i_out_ready),
        .o_slot_free   (slot_free),
        .o_out_valid   (o_out_valid),
        .o_data_out    (o_data_out),
        .o_valid_bytes (o_valid_bytes)
    );

endmodule

/* rtl/fkc_checker.sv */
// Port-level assertion checker of the keystream cipher and its bind statement.
`include "five_register_keystream_cipher_defines.svh"

module fkc_checker
    import fkc_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  o_in_ready,
    input logic  i_kind,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input t_word o_data_out,
    input t_bcnt o_valid_bytes
);

    // A stalled result keeps its value.
    `FKC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_data_out))

    // The key setup blocks new requests in the cycle after a restart request.
    `FKC_ASSERT_NEXT(a_setup_busy, i_in_valid && o_in_ready && (i_kind == KIND_RESTART), !o_in_ready)

    // Every accepted data request presents a result in the following cycle.
    `FKC_ASSERT_NEXT(a_data_result, i_in_valid && o_in_ready && (i_kind == KIND_DATA), o_out_valid)

    // A result never reports more than eight bytes.
    `FKC_ASSERT_IMP(a_count_range, o_out_valid, o_valid_bytes <= t_bcnt'(NUM_BYTES))

    // A one-byte result has all higher bytes cleared.
    `FKC_ASSERT_IMP(a_mask_one, o_out_valid && (o_valid_bytes == t_bcnt'(1)), o_data_out[63:8] == '0)

endmodule

bind five_register_keystream_cipher fkc_checker u_checker (.*);

/* dv/tb_five_register_keystream_cipher.sv */
// Self-checking testbench for the five-register keystream cipher, with its own cipher predictor.
module tb_five_register_keystream_cipher;
    import fkc_pkg::*;

    localparam int unsigned CYCLE_LIMIT       = 400000;
    localparam int unsigned LONG_STALL_CYCLES = 80;
    localparam int unsigned SETTLE_CYCLES     = 12;
    localparam int unsigned PHASE_REQUESTS    = 115;
    localparam int unsigned NUM_PHASES        = 8;
    localparam int unsigned MAX_PRINTED       = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam t_word ALL_ONES = '1;

    typedef enum int {
        KEYS_ZERO,
        KEYS_ONES,
        KEYS_RANDOM,
        KEYS_MIXED
    } t_key_style;

    typedef struct {
        logic  kind;
        t_word data;
        t_bcnt count;
    } t_block_req;

    typedef struct {
        t_word data;
        t_bcnt count;
    } t_block_res;

    typedef struct {
        logic [CFG_IDX_W-1:0] index;
        t_word                value;
    } t_reg_write;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    t_word                i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_ready;
    logic                 i_kind        = 1'b0;
    t_word                i_data_in     = '0;
    t_bcnt                i_byte_count  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready   = 1'b0;
    t_word                o_data_out;
    t_bcnt                o_valid_bytes;

    t_block_req  block_requests[$];
    t_reg_write  reg_writes[$];
    t_block_res  expected_blocks[$];

    t_word       key_words[4];
    t_word       iv_words[2];
    t_word       cipher_sr[4];
    t_word       cipher_acc;

    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned src_idle     = 0;
    int unsigned sink_idle    = 0;
    int unsigned stall_count  = 0;
    logic        hold_sink    = 1'b0;
    logic        stall_done   = 1'b0;
    logic        quiet_run    = 1'b0;
    logic        block_taken;
    logic        write_taken;
    t_block_req  next_block;
    t_block_res  observed;
    t_reg_write  next_write;

    five_register_keystream_cipher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_data_in     (i_data_in),
        .i_byte_count  (i_byte_count),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_out    (o_data_out),
        .o_valid_bytes (o_valid_bytes)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_word rol(input t_word a, input int unsigned n);
        logic [2*WORD_W-1:0] twice;
        twice = {a, a} << n;
        return twice[2*WORD_W-1 -: WORD_W];
    endfunction

    function automatic t_word sr_sum();
        return cipher_sr[0] + cipher_sr[1] + cipher_sr[2] + cipher_sr[3];
    endfunction

    function automatic void rotate_state();
        cipher_sr[0] = rol(cipher_sr[0], 2);
        cipher_sr[1] = rol(cipher_sr[1], 7);
        cipher_sr[2] = rol(cipher_sr[2], 9);
        cipher_sr[3] = rol(cipher_sr[3], 12);
        cipher_acc   = rol(cipher_acc, 5);
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] index,
                                            input t_word value);
        case (index)
            CFG_KEY0: key_words[0] = value;
            CFG_KEY1: key_words[1] = value;
            CFG_KEY2: key_words[2] = value;
            CFG_KEY3: key_words[3] = value;
            CFG_IV0:  iv_words[0]  = value;
            CFG_IV1:  iv_words[1]  = value;
            default: ;
        endcase
    endfunction

    function automatic void load_key_schedule();
        t_word chain;
        for (int i = 0; i < 4; i++) cipher_sr[i] = key_words[i];
        cipher_acc = sr_sum();
        cipher_sr[2] ^= iv_words[0];
        cipher_sr[3] ^= iv_words[1];
        chain = sr_sum() + t_word'(1);
        for (int i = 0; i < 4; i++) begin
            chain = sr_sum() + chain;
            cipher_sr[i] = chain;
        end
        cipher_acc += cipher_sr[1] + cipher_sr[2] + cipher_sr[3];
        rotate_state();
    endfunction

    function automatic void advance_cipher(input t_block_req req);
        t_word      r;
        t_word      keystream;
        t_word      mask;
        t_bcnt      n;
        t_block_res res;
        if (req.kind == KIND_RESTART) begin
            load_key_schedule();
            return;
        end
        r = cipher_sr[0];
        cipher_sr[0] = (r << 11) ^ (r << 12) ^ (r >> 6) ^ (r >> 3);
        r = cipher_sr[1];
        cipher_sr[1] = (r << 9) ^ (r << 13) ^ (r >> 5) ^ (r >> 1);
        r = cipher_sr[2];
        cipher_sr[2] = (r << 1) ^ (r << 2) ^ (r >> 3) ^ (r >> 1);
        r = cipher_sr[3];
        cipher_sr[3] = (r << 14) ^ (r << 16) ^ (r >> 7) ^ (r >> 2);
        cipher_acc += sr_sum();
        rotate_state();
        keystream = cipher_sr[0] ^ cipher_sr[1] ^ cipher_sr[2] ^ cipher_sr[3] ^ cipher_acc;
        n = (req.count > t_bcnt'(NUM_BYTES)) ? t_bcnt'(NUM_BYTES) : req.count;
        mask = (n == t_bcnt'(NUM_BYTES)) ? ALL_ONES : ((t_word'(1) << (8 * n)) - t_word'(1));
        res.data  = (req.data ^ keystream) & mask;
        res.count = n;
        expected_blocks.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("MISMATCH %s: got %h, expected %h", what, got, want);
        end
    endtask

    task automatic push_block(input logic kind, input t_word data, input t_bcnt count);
        t_block_req req;
        req.kind  = kind;
        req.data  = data;
        req.count = count;
        block_requests.push_back(req);
    endtask

    task automatic push_write(input logic [CFG_IDX_W-1:0] index, input t_word value);
        t_reg_write w;
        w.index = index;
        w.value = value;
        reg_writes.push_back(w);
    endtask

    function automatic t_word pick_word(input t_key_style style);
        case (style)
            KEYS_ZERO:   return '0;
            KEYS_ONES:   return ALL_ONES;
            KEYS_RANDOM: return {$urandom(), $urandom()};
            default: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return ALL_ONES;
                    2:       return 64'h8000_0000_0000_0001;
                    default: return {$urandom(), $urandom()};
                endcase
            end
        endcase
    endfunction

    task automatic program_keys(input t_key_style style);
        push_write(CFG_KEY0, pick_word(style));
        push_write(CFG_KEY1, pick_word(style));
        push_write(CFG_KEY2, pick_word(style));
        push_write(CFG_KEY3, pick_word(style));
        push_write(CFG_IV0, pick_word(style));
        push_write(CFG_IV1, pick_word(style));
        push_write(CFG_SPARE_LO, {$urandom(), $urandom()});
        push_write(CFG_SPARE_HI, {$urandom(), $urandom()});
    endtask

    task automatic queue_random_traffic(input int unsigned n_requests);
        t_word       data;
        t_bcnt       count;
        int unsigned roll;
        push_block(KIND_RESTART, {$urandom(), $urandom()}, t_bcnt'($urandom_range(0, 15)));
        for (int i = 1; i < n_requests; i++) begin
            roll = $urandom_range(0, 19);
            case (roll)
                0:       data = '0;
                1:       data = ALL_ONES;
                default: data = {$urandom(), $urandom()};
            endcase
            roll = $urandom_range(0, 19);
            if (roll == 0) count = t_bcnt'($urandom_range(9, 15));
            else if (roll == 1) count = '0;
            else count = t_bcnt'($urandom_range(1, 8));
            if ($urandom_range(0, 99) < 6) push_block(KIND_RESTART, data, count);
            else push_block(KIND_DATA, data, count);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (block_requests.size() != 0 || i_in_valid || reg_writes.size() != 0 ||
               i_cfg_valid || expected_blocks.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < 4; i++) begin
            key_words[i] = '0;
            cipher_sr[i] = '0;
        end
        iv_words[0] = '0;
        iv_words[1] = '0;
        cipher_acc  = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            write_taken = i_cfg_valid && o_cfg_ready;
            if (write_taken) apply_reg_write(i_cfg_index, i_cfg_data);
            if (!i_cfg_valid || write_taken) begin
                if (reg_writes.size() != 0) begin
                    next_write = reg_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= next_write.index;
                    i_cfg_data  <= next_write.value;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            block_taken = i_in_valid && o_in_ready;
            if (block_taken) begin
                next_block.kind  = i_kind;
                next_block.data  = i_data_in;
                next_block.count = i_byte_count;
                advance_cipher(next_block);
            end
            if (!i_in_valid || block_taken) begin
                if (src_idle != 0) begin
                    src_idle--;
                    i_in_valid <= 1'b0;
                end else if (block_requests.size() != 0) begin
                    next_block = block_requests.pop_front();
                    i_in_valid   <= 1'b1;
                    i_kind       <= next_block.kind;
                    i_data_in    <= next_block.data;
                    i_byte_count <= next_block.count;
                    if (!quiet_run && $urandom_range(0, 7) == 0) begin
                        src_idle = $urandom_range(1, 7);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_sink && !stall_done) begin
            i_out_ready <= (stall_count == LONG_STALL_CYCLES);
            if (stall_count == LONG_STALL_CYCLES) stall_done = 1'b1;
            else stall_count++;
        end else if (sink_idle != 0) begin
            sink_idle--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet_run && $urandom_range(0, 7) == 0) sink_idle = $urandom_range(1, 7);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch("result with no request outstanding", o_data_out, '0);
            end else begin
                observed = expected_blocks.pop_front();
                if (o_data_out !== observed.data) begin
                    report_mismatch("data_out", o_data_out, observed.data);
                end
                if (o_valid_bytes !== observed.count) begin
                    report_mismatch("valid_bytes", t_word'(o_valid_bytes), t_word'(observed.count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Data requests ahead of any restart run from the cleared state.
        push_block(KIND_DATA, ALL_ONES, 4'd8);
        push_block(KIND_DATA, '0, 4'd1);
        push_block(KIND_RESTART, ALL_ONES, 4'd15);
        push_block(KIND_DATA, ALL_ONES, 4'd0);
        push_block(KIND_DATA, ALL_ONES, 4'd15);
        push_block(KIND_DATA, {$urandom(), $urandom()}, 4'd9);
        push_block(KIND_DATA, 64'h0123_4567_89AB_CDEF, 4'd8);
        for (int n = 1; n < 8; n++) push_block(KIND_DATA, ALL_ONES, t_bcnt'(n));
        wait_drained();

        program_keys(KEYS_ONES);
        wait_drained();
        push_block(KIND_RESTART, '0, 4'd0);
        push_block(KIND_DATA, '0, 4'd8);
        push_block(KIND_DATA, ALL_ONES, 4'd4);
        push_block(KIND_DATA, 64'h8000_0000_0000_0001, 4'd8);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_keys(t_key_style'(p % 4));
            wait_drained();
            if (p == 3) hold_sink = 1'b1;
            if (p == NUM_PHASES - 1) quiet_run = 1'b1;
            queue_random_traffic(PHASE_REQUESTS);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
